// ----- hdl/rwpg_pkg.sv -----
`default_nettype none

package rwpg_pkg;

  localparam int PHASE_BITS = 16;
  localparam int COL_BITS   = 6;
  localparam int NUM_CH     = 3;

  // Channel order inside the packed vectors.
  localparam int CH_RED = 0;
  localparam int CH_GRN = 1;
  localparam int CH_BLU = 2;

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic [NUM_CH-1:0][PHASE_BITS-1:0] phase_vec_t;
  typedef logic [3:0] nibble_t;
  typedef logic [NUM_CH-1:0][3:0] nibble_vec_t;

  // Radian steps as Q0.32 fractions of a turn: 1/2, 1/3, 1/4, 0.3 and 0.2 rad.
  localparam logic [31:0] TURN_HALF_RAD  = 32'd341782638;
  localparam logic [31:0] TURN_THIRD_RAD = 32'd227855092;
  localparam logic [31:0] TURN_QUART_RAD = 32'd170891319;
  localparam logic [31:0] TURN_P3_RAD    = 32'd205069583;
  localparam logic [31:0] TURN_P2_RAD    = 32'd136713055;

  // Rounds a Q0.32 turn fraction to the phase width, ties up.
  function automatic phase_t to_phase(input logic [31:0] q32);
    logic [32:0] sum;
    sum = {1'b0, q32} + (33'd1 << (31 - PHASE_BITS));
    return sum[32-PHASE_BITS +: PHASE_BITS];
  endfunction

  localparam phase_vec_t COL_STEP = {to_phase(TURN_QUART_RAD),
                                     to_phase(TURN_THIRD_RAD),
                                     to_phase(TURN_HALF_RAD)};
  localparam phase_vec_t FRM_STEP = {to_phase(TURN_P2_RAD),
                                     to_phase(TURN_P3_RAD),
                                     to_phase(TURN_HALF_RAD)};

  localparam int PROD_BITS = 2 * PHASE_BITS - 3;
  localparam int VAL_BITS  = 2 * PHASE_BITS + 1;

  localparam nibble_t NIB_MAX = 4'd14;

  // Load enables of the sine stages.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } rwpg_load_t;

endpackage

`default_nettype wire

// ----- hdl/rgb_wave_pattern_generator.sv -----
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------
// in       | in_valid / in_ready    | in_column[5:0], in_end_of_frame
// out      | out_valid / out_ready  | out_color[11:0] (R 11:8, G 7:4, B 3:0)
//
// One pixel enters per clock while the output side drains; its color leaves
// after the angle, product, sine value and nibble register stages.
// Reset clears the three phase accumulators and empties the pipeline.
// A stall on out_ready holds the last stage; in_ready drops only when every
// stage holds a valid transaction, and bubbles are squeezed out on the way.
`default_nettype none

module rgb_wave_pattern_generator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rwpg_pkg::COL_BITS-1:0] in_column,
  input  wire logic                          in_end_of_frame,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [11:0]                        out_color
);
  import rwpg_pkg::*;

  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  logic v4_r, v4_nxt;
  logic en1, en2, en3, en4;
  logic accept;
  rwpg_load_t  load;
  phase_vec_t  angle;
  nibble_vec_t nib;

  always_comb begin
    en4    = !v4_r || out_ready;
    en3    = !v3_r || en4;
    en2    = !v2_r || en3;
    en1    = !v1_r || en2;
    accept = in_valid && en1;
    v1_nxt = en1 ? accept : v1_r;
    v2_nxt = en2 ? v1_r : v2_r;
    v3_nxt = en3 ? v2_r : v3_r;
    v4_nxt = en4 ? v3_r : v4_r;
    load   = '{s2: en2, s3: en3, s4: en4};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  rwpg_angle u_angle (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .load         (en1),
    .column       (in_column),
    .end_of_frame (in_end_of_frame),
    .angle        (angle)
  );

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    rwpg_sine u_sine (
      .clk    (clk),
      .load   (load),
      .angle  (angle[c]),
      .nibble (nib[c])
    );
  end

  assign in_ready  = en1;
  assign out_valid = v4_r;
  assign out_color = {nib[CH_RED], nib[CH_GRN], nib[CH_BLU]};

endmodule

`default_nettype wire

// ----- hdl/rwpg_angle.sv -----
`default_nettype none

module rwpg_angle (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic                         load,
  input  wire logic [rwpg_pkg::COL_BITS-1:0] column,
  input  wire logic                         end_of_frame,
  output rwpg_pkg::phase_vec_t              angle
);
  import rwpg_pkg::*;

  phase_vec_t phase_r, phase_nxt;
  phase_vec_t angle_r, angle_nxt;
  logic [NUM_CH-1:0][COL_BITS+PHASE_BITS-1:0] col_prod;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      col_prod[c]  = {{PHASE_BITS{1'b0}}, column} * {{COL_BITS{1'b0}}, COL_STEP[c]};
      angle_nxt[c] = phase_r[c] + col_prod[c][PHASE_BITS-1:0];
      // The phases move only after the last pixel of a frame has used them.
      phase_nxt[c] = (accept && end_of_frame) ? phase_r[c] + FRM_STEP[c] : phase_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      angle_r <= angle_nxt;
    end
  end

  assign angle = angle_r;

endmodule

`default_nettype wire

// ----- hdl/rwpg_sine.sv -----
`default_nettype none

module rwpg_sine (
  input  wire logic              clk,
  input  wire rwpg_pkg::rwpg_load_t load,
  input  wire rwpg_pkg::phase_t  angle,
  output rwpg_pkg::nibble_t      nibble
);
  import rwpg_pkg::*;

  localparam phase_t                HALF_TURN = phase_t'(1) << (PHASE_BITS - 1);
  localparam logic [VAL_BITS-1:0]   VAL_MID   = VAL_BITS'(1) << (2 * PHASE_BITS - 1);

  // Stage 2: |u| * (1/2 - |u|) and the sign of u.
  logic                     neg;
  phase_t                   mag;
  phase_t                   rest;
  logic [2*PHASE_BITS-1:0]  prod_full;
  logic [PROD_BITS-1:0]     prod_r, prod_nxt;
  logic                     neg_r;

  always_comb begin
    neg       = !angle[PHASE_BITS-1];
    mag       = neg ? HALF_TURN - {1'b0, angle[PHASE_BITS-2:0]}
                    : {1'b0, angle[PHASE_BITS-2:0]};
    rest      = HALF_TURN - mag;
    prod_full = {{PHASE_BITS{1'b0}}, mag} * {{PHASE_BITS{1'b0}}, rest};
    prod_nxt  = prod_full[PROD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (load.s2) begin
      prod_r <= prod_nxt;
      neg_r  <= neg;
    end
  end

  // Stage 3: value = 1/2 + 8u(1/2 - |u|), which stays in 0..1.
  logic [VAL_BITS-1:0] scaled;
  logic [VAL_BITS-1:0] val_r, val_nxt;

  always_comb begin
    scaled  = {1'b0, prod_r, 3'b000};
    val_nxt = neg_r ? VAL_MID - scaled : VAL_MID + scaled;
  end

  always_ff @(posedge clk) begin
    if (load.s3) begin
      val_r <= val_nxt;
    end
  end

  // Stage 4: floor(14 * value), clamped, plus one.
  logic [VAL_BITS+3:0] times14;
  logic [4:0]          whole;
  nibble_t             nib_nxt, nib_r;

  always_comb begin
    times14 = {val_r, 4'b0000} - {3'b000, val_r, 1'b0};
    whole   = times14[2*PHASE_BITS +: 5];
    nib_nxt = ((whole > {1'b0, NIB_MAX}) ? NIB_MAX : whole[3:0]) + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (load.s4) begin
      nib_r <= nib_nxt;
    end
  end

  assign nibble = nib_r;

endmodule

`default_nettype wire

// ----- hdl/rwpg_checker.sv -----
`default_nettype none

module rwpg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [11:0] out_color
);

  // The pipeline is empty after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // A stalled result transaction holds its color.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_color))
    else $error("result changed or vanished while stalled");

  // A free output side never throttles the input.
  a_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("in_ready low although the output side can drain");

  // Every nibble of a delivered color lies in 1..15.
  a_nibble_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_color[11:8] != 4'd0) && (out_color[7:4] != 4'd0)
                  && (out_color[3:0] != 4'd0))
    else $error("color nibble out of range");

  // An input transaction reaches the output only after passing the pipeline stages.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) |=> !($past(in_valid && in_ready, 2)
      && out_valid && !$past(out_valid) && !$past(in_valid && in_ready, 3)
      && !$past(in_valid && in_ready, 4) && !$past(in_valid && in_ready, 5)
      && !$past(in_valid && in_ready, 1)))
    else $error("result appeared too early");

endmodule

bind rgb_wave_pattern_generator rwpg_checker u_rwpg_checker (.*);

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rwpg_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int PIPE_LATENCY  = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_FRAMES = 14;
  localparam int NOISE_ITEMS   = 200;
  localparam int COL_MAX       = (1 << COL_BITS) - 1;

  // Angular steps in radians, as Q0.32 fractions of one turn.
  localparam logic [31:0] Q32_RAD_HALF  = 32'd341782638;
  localparam logic [31:0] Q32_RAD_THIRD = 32'd227855092;
  localparam logic [31:0] Q32_RAD_QUART = 32'd170891319;
  localparam logic [31:0] Q32_RAD_0P3   = 32'd205069583;
  localparam logic [31:0] Q32_RAD_0P2   = 32'd136713055;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [COL_BITS-1:0] in_column = '0;
  logic                in_end_of_frame = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [11:0]         out_color;

  phase_t      wave_red, wave_grn, wave_blu;
  logic [11:0] expected_colors[$];

  int burst_left;
  int pixels_sent;
  int frames_ended;
  int colors_checked;
  int error_count;
  int idle_cycles;
  int stall_mode;
  int stall_span;

  rgb_wave_pattern_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_column       (in_column),
    .in_end_of_frame (in_end_of_frame),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_color       (out_color)
  );

  always #CLK_HALF clk = ~clk;

  // Rounds a Q0.32 turn fraction to the accumulator width, halves rounding up.
  function automatic phase_t turn_step(input logic [31:0] q32);
    longint unsigned rounded;
    rounded = (longint'(q32) + (longint'(1) << (31 - PHASE_BITS))) >> (32 - PHASE_BITS);
    return phase_t'(rounded);
  endfunction

  // Parabolic sine of one angle, scaled to a 1..15 intensity nibble.
  function automatic nibble_t wave_nibble(input phase_t angle);
    longint offs, mag, level, scaled;
    offs   = longint'(angle) - (longint'(1) << (PHASE_BITS - 1));
    mag    = (offs < 0) ? -offs : offs;
    level  = (longint'(1) << (2 * PHASE_BITS - 1))
           + offs * (longint'(1) << (PHASE_BITS + 2)) - 8 * offs * mag;
    if (level < 0) return nibble_t'(1);
    scaled = (level * 14) >>> (2 * PHASE_BITS);
    if (scaled > 14) scaled = 14;
    return nibble_t'(scaled + 1);
  endfunction

  function automatic nibble_t column_nibble(input logic [COL_BITS-1:0] col,
                                            input logic [31:0] col_q32,
                                            input phase_t acc);
    logic [31:0] sum;
    sum = 32'(col) * 32'(turn_step(col_q32)) + 32'(acc);
    return wave_nibble(phase_t'(sum));
  endfunction

  // Expected color for an accepted pixel, then the frame-end phase advance.
  task automatic predict_color(input logic [COL_BITS-1:0] col, input logic eof);
    expected_colors.push_back({column_nibble(col, Q32_RAD_HALF, wave_red),
                               column_nibble(col, Q32_RAD_THIRD, wave_grn),
                               column_nibble(col, Q32_RAD_QUART, wave_blu)});
    if (eof) begin
      wave_red = wave_red + turn_step(Q32_RAD_HALF);
      wave_grn = wave_grn + turn_step(Q32_RAD_0P3);
      wave_blu = wave_blu + turn_step(Q32_RAD_0P2);
      frames_ended++;
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  task automatic send_pixel(input logic [COL_BITS-1:0] col, input logic eof);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_column       <= col;
    in_end_of_frame <= eof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_color(col, eof);
    pixels_sent++;
  endtask

  task automatic flag_error(input string msg);
    if (error_count < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic test_column_extremes();
    logic [COL_BITS-1:0] cols[10];
    cols = '{6'd0, 6'd63, 6'd1, 6'd62, 6'd21, 6'd42, 6'd32, 6'd31, 6'd15, 6'd48};
    foreach (cols[i]) send_pixel(cols[i], 1'b0);
  endtask

  // Frame ends on both extreme columns, including back-to-back frame ends.
  task automatic test_frame_advance();
    send_pixel(6'd63, 1'b1);
    send_pixel(6'd0, 1'b0);
    send_pixel(6'd0, 1'b1);
    send_pixel(6'd63, 1'b0);
    for (int i = 0; i < 6; i++) send_pixel(COL_MAX[COL_BITS-1:0] - i[COL_BITS-1:0], 1'b1);
  endtask

  // Enough consecutive frame ends that every accumulator wraps past a full turn.
  task automatic test_wrapped_phases();
    for (int i = 0; i < 80; i++) send_pixel(COL_BITS'($urandom_range(0, COL_MAX)), 1'b1);
  endtask

  // Well-formed frames: one or more rows of ascending columns, frame end on the
  // last pixel. Some rows are cut short.
  task automatic test_random_frames();
    int rows, width;
    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      rows = $urandom_range(1, 2);
      for (int r = 0; r < rows; r++) begin
        width = ($urandom_range(0, 2) == 0) ? $urandom_range(1, COL_MAX + 1) : COL_MAX + 1;
        for (int c = 0; c < width; c++)
          send_pixel(COL_BITS'(c), (r == rows - 1) && (c == width - 1));
      end
    end
  endtask

  task automatic test_noise();
    for (int i = 0; i < NOISE_ITEMS; i++)
      send_pixel(COL_BITS'($urandom_range(0, COL_MAX)), $urandom_range(0, 7) == 0);
  endtask

  // Receiver: stall behavior switches between modes after spans of random length.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(16, 300);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_span % 9) < 6;
    endcase
  end

  always @(posedge clk) begin
    logic [11:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_colors.size() == 0) begin
        flag_error($sformatf("unexpected color transaction %03h", out_color));
      end else begin
        want = expected_colors.pop_front();
        colors_checked++;
        if (out_color !== want)
          flag_error($sformatf("color %0d: expected R%h G%h B%h, got R%h G%h B%h",
                               colors_checked, want[11:8], want[7:4], want[3:0],
                               out_color[11:8], out_color[7:4], out_color[3:0]));
      end
    end
  end

  // Watchdog on cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    wave_red       = '0;
    wave_grn       = '0;
    wave_blu       = '0;
    burst_left     = 0;
    pixels_sent    = 0;
    frames_ended   = 0;
    colors_checked = 0;
    error_count    = 0;
    idle_cycles    = 0;
    stall_mode     = 0;
    stall_span     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_column_extremes();
    test_frame_advance();
    test_wrapped_phases();
    test_random_frames();
    test_noise();
    in_valid <= 1'b0;

    while (expected_colors.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (expected_colors.size() != 0)
      flag_error($sformatf("%0d colors never arrived", expected_colors.size()));

    $display("Sent %0d pixels across %0d frame ends; %0d colors checked, %0d errors.",
             pixels_sent, frames_ended, colors_checked, error_count);
    $display("Covered column extremes, back-to-back frame ends and phase wraparound.");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
